// ===== hw/rtl/isru_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isru_pkg
// Shared types, constants and the icon segment table of the segment RAM updater.
// ----------------------------------------------------------------------------
package isru_pkg;

  localparam int MEMORY_WORDS = 32;
  localparam int ICON_COUNT   = 19;
  localparam int MAX_SEGMENTS = 13;
  localparam int TABLE_ICONS  = 19;
  localparam int TABLE_SEGS   = 13;
  localparam int RESULT_LIMIT = 32;

  localparam int OP_W    = 2;
  localparam int ICON_W  = 5;
  localparam int MASK_W  = 13;
  localparam int ADDR_W  = 5;
  localparam int NIB_W   = 4;
  localparam int CFG_W   = 6;
  localparam int CNT_W   = 6;
  localparam int CODE_W  = 8;
  localparam int SEG_IW  = $clog2(TABLE_SEGS);
  localparam int MEM_AW  = $clog2(MEMORY_WORDS);

  localparam logic [CFG_W-1:0] BLANK_RESET = CFG_W'(30);
  localparam logic [NIB_W-1:0] NIB_FULL    = {NIB_W{1'b1}};
  localparam logic [NIB_W-1:0] NIB_EMPTY   = '0;

  typedef enum logic [OP_W-1:0] {
    OP_ICON  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FILL  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
  } dp_sts_t;

  localparam logic [CODE_W-1:0] SEG_TABLE [TABLE_ICONS][TABLE_SEGS] = '{
    '{8'hC1, 8'h81, 8'h41, 8'h02, 8'h42, 8'hC2, 8'h82, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hC3, 8'h83, 8'h43, 8'h04, 8'h44, 8'hC4, 8'h84, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hC5, 8'h85, 8'h45, 8'h13, 8'h53, 8'hD3, 8'h93, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hC6, 8'h86, 8'h46, 8'h07, 8'h47, 8'hC7, 8'h87, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hC8, 8'h88, 8'h48, 8'h09, 8'h49, 8'hC9, 8'h89, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hCA, 8'h8A, 8'h4A, 8'h0B, 8'h4B, 8'hCB, 8'h8B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hCC, 8'h8C, 8'h4C, 8'h0D, 8'h4D, 8'hCD, 8'h8D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hDA, 8'h9A, 8'h5A, 8'h1B, 8'h5B, 8'hDB, 8'h9B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h01, 8'h03, 8'h05, 8'h06, 8'h08, 8'h0A, 8'h0C, 8'h1A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hD0, 8'h90, 8'h97, 8'hD7, 8'hD1, 8'hD2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h10, 8'h50, 8'h57, 8'h17, 8'h11, 8'h51, 8'h91, 8'h92, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hCF, 8'h8F, 8'h4F, 8'h00, 8'h40, 8'hCE, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h12, 8'h0E, 8'h4E, 8'h52, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hD8, 8'h98, 8'h58, 8'h19, 8'h59, 8'hD9, 8'h99, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hD5, 8'h95, 8'h55, 8'h15, 8'h16, 8'h56, 8'h96, 8'hD6, 8'hD4, 8'h94, 8'h54, 8'h14, 8'h0F},
    '{8'h1D, 8'h9D, 8'hDD, 8'h5D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h1C, 8'h5C, 8'h9C, 8'hDC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h8E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [CNT_W-1:0] SEG_COUNT [TABLE_ICONS] = '{
    6'd7, 6'd7, 6'd7, 6'd7, 6'd7, 6'd7, 6'd7, 6'd7, 6'd8, 6'd6,
    6'd8, 6'd7, 6'd5, 6'd7, 6'd13, 6'd4, 6'd4, 6'd1, 6'd1
  };

  function automatic logic [CODE_W-1:0] seg_code(logic [ICON_W-1:0] icon,
                                                 logic [SEG_IW-1:0] seg);
    logic [CODE_W-1:0] code;
    code = '0;
    if ({1'b0, icon} < (ICON_W+1)'(TABLE_ICONS) && {1'b0, seg} < (SEG_IW+1)'(TABLE_SEGS)) begin
      code = SEG_TABLE[icon][seg];
    end
    return code;
  endfunction

  function automatic logic [CNT_W-1:0] icon_seg_count(logic [ICON_W-1:0] icon);
    logic [CNT_W-1:0] cnt;
    cnt = '0;
    if ({1'b0, icon} < (ICON_W+1)'(ICON_COUNT) && {1'b0, icon} < (ICON_W+1)'(TABLE_ICONS)) begin
      cnt = SEG_COUNT[icon];
      if (cnt > CNT_W'(MAX_SEGMENTS)) begin
        cnt = CNT_W'(MAX_SEGMENTS);
      end
      if (cnt > CNT_W'(TABLE_SEGS)) begin
        cnt = CNT_W'(TABLE_SEGS);
      end
    end
    return cnt;
  endfunction

  function automatic logic [CNT_W-1:0] blank_count(logic [CFG_W-1:0] words);
    logic [CNT_W-1:0] cnt;
    cnt = CNT_W'(words);
    if ({1'b0, cnt} > (CNT_W+1)'(MEMORY_WORDS)) begin
      cnt = CNT_W'(MEMORY_WORDS);
    end
    if ({1'b0, cnt} > (CNT_W+1)'(RESULT_LIMIT)) begin
      cnt = CNT_W'(RESULT_LIMIT);
    end
    return cnt;
  endfunction

endpackage

// ===== hw/rtl/icon_segment_ram_updater.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icon_segment_ram_updater
// Segment LCD display memory (32 x 4) with icon update, clear-all, fill-all.
// ----------------------------------------------------------------------------
// Usage:
//   Command: pulse start_i with operation_i, icon_i, mask_i while busy_o is
//   low; the transaction is taken at that edge. busy_o stays high until the
//   command is finished.
//   Results: one per display word written, each shown for exactly one cycle
//   with result_strobe_o high; last_o marks the final write of the command.
//   The receiver cannot stall, so no backpressure exists.
//   Sequence: the command is loaded, then one read-modify-write of the
//   register-file display memory per table segment or per blanked word,
//   then a flush. An unknown icon or operation 3 gives no result.
//   Config: cfg_valid_i/cfg_ready_o write blank_words (ready is always high);
//   write only while idle.
//   Reset: display memory cleared to zero, blank_words set to 30, idle.
// ----------------------------------------------------------------------------
module icon_segment_ram_updater
  import isru_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [ICON_W-1:0] icon_i,
  input  logic [MASK_W-1:0] mask_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output logic              result_strobe_o,
  output logic [ADDR_W-1:0] ram_address_o,
  output logic [NIB_W-1:0]  nibble_o,
  output logic              last_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready_o = 1'b1;

  isru_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  isru_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .icon_i          (icon_i),
    .mask_i          (mask_i),
    .cfg_write_i     (cfg_valid_i & cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .result_strobe_o (result_strobe_o),
    .ram_address_o   (ram_address_o),
    .nibble_o        (nibble_o),
    .last_o          (last_o)
  );

endmodule

// ===== hw/rtl/isru_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isru_ctrl
// Sequencer: loads a command, steps the datapath per word, then flushes.
// ----------------------------------------------------------------------------
module isru_ctrl
  import isru_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o,
  output logic      busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        busy_o = 1'b1;
        if (sts_i.done) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/isru_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isru_dp
// Datapath: display memory, walk counter, read-modify-write and result stage.
// ----------------------------------------------------------------------------
module isru_dp
  import isru_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output dp_sts_t           sts_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [ICON_W-1:0] icon_i,
  input  logic [MASK_W-1:0] mask_i,
  input  logic              cfg_write_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output logic              result_strobe_o,
  output logic [ADDR_W-1:0] ram_address_o,
  output logic [NIB_W-1:0]  nibble_o,
  output logic              last_o
);

  logic [NIB_W-1:0]  mem_q [MEMORY_WORDS];
  logic [CFG_W-1:0]  blank_q;
  op_e               op_q;
  logic [ICON_W-1:0] icon_q;
  logic [MASK_W-1:0] mask_q;
  logic [CNT_W-1:0]  idx_q, cnt_q, cnt_d;

  logic              pend_v_q;
  logic [ADDR_W-1:0] pend_addr_q;
  logic [NIB_W-1:0]  pend_nib_q;

  logic              out_v_q, out_v_d, out_last_q, out_last_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  logic [NIB_W-1:0]  out_nib_q, out_nib_d;

  logic [CODE_W-1:0] code;
  logic [CNT_W-1:0]  wr_addr;
  logic              wr_hit;
  logic [MEM_AW-1:0] wr_idx;
  logic [NIB_W-1:0]  bit_sel, new_nib;

  assign sts_o.done = (idx_q == cnt_q);

  always_comb begin
    case (op_e'(operation_i))
      OP_ICON:           cnt_d = icon_seg_count(icon_i);
      OP_CLEAR, OP_FILL: cnt_d = blank_count(blank_q);
      default:           cnt_d = '0;
    endcase
  end

  always_comb begin
    code    = seg_code(icon_q, idx_q[SEG_IW-1:0]);
    bit_sel = NIB_W'(1) << code[CODE_W-1:CODE_W-2];
    if (op_q == OP_ICON) begin
      wr_addr = CNT_W'(code[5:0]);
      wr_hit  = {1'b0, wr_addr} < (CNT_W+1)'(MEMORY_WORDS);
      wr_idx  = wr_addr[MEM_AW-1:0];
      if (mask_q[idx_q[SEG_IW-1:0]]) begin
        new_nib = mem_q[wr_idx] | bit_sel;
      end else begin
        new_nib = mem_q[wr_idx] & ~bit_sel;
      end
    end else begin
      wr_addr = idx_q;
      wr_hit  = 1'b1;
      wr_idx  = idx_q[MEM_AW-1:0];
      new_nib = (op_q == OP_FILL) ? NIB_FULL : NIB_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MEMORY_WORDS; i++) begin
        mem_q[i] <= '0;
      end
    end else if (cmd_i.step && wr_hit) begin
      mem_q[wr_idx] <= new_nib;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q <= BLANK_RESET;
    end else if (cfg_write_i) begin
      blank_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(operation_i);
      icon_q <= icon_i;
      mask_q <= mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
      cnt_q <= cnt_d;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + CNT_W'(1);
    end else if (cmd_i.flush) begin
      idx_q <= '0;
      cnt_q <= '0;
    end
  end

  // one write held back so the final one can carry last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
    end else if (cmd_i.step && wr_hit) begin
      pend_v_q <= 1'b1;
    end else if (cmd_i.flush) begin
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && wr_hit) begin
      pend_addr_q <= wr_addr[ADDR_W-1:0];
      pend_nib_q  <= new_nib;
    end
  end

  always_comb begin
    out_v_d    = 1'b0;
    out_last_d = 1'b0;
    out_addr_d = pend_addr_q;
    out_nib_d  = pend_nib_q;
    if (cmd_i.step && wr_hit && pend_v_q) begin
      out_v_d = 1'b1;
    end else if (cmd_i.flush && pend_v_q) begin
      out_v_d    = 1'b1;
      out_last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_last_q <= out_last_d;
    out_addr_q <= out_addr_d;
    out_nib_q  <= out_nib_d;
  end

  assign result_strobe_o = out_v_q;
  assign ram_address_o   = out_addr_q;
  assign nibble_o        = out_nib_q;
  assign last_o          = out_last_q;

endmodule
